// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: hdl/fuds_pkg.sv
// types, constants and helper functions of the form-encoded splitter and decoder
package fuds_pkg;

    localparam int PAIR_INDEX_RANGE_DEF = 1024;
    localparam int PAIR_LIMIT_W         = 10;
    localparam int PAIR_INDEX_W         = 10;
    localparam logic [PAIR_LIMIT_W-1:0] PAIR_LIMIT_RST = 10'd509;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       pair_done;
    } slot_t;

    // up to three results caused by one input item
    typedef struct packed {
        logic [1:0]              cnt;
        slot_t [2:0]             slots;
        logic                    value_part;
        logic [PAIR_INDEX_W-1:0] pair_index;
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
               ((c >= CH_LA) && (c <= CH_LF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CH_LA) begin
            d = c - CH_LA + 8'd10;
        end else if (c >= CH_UA) begin
            d = c - CH_UA + 8'd10;
        end else begin
            d = c - CH_0;
        end
        return d[3:0];
    endfunction

endpackage

// File: hdl/fuds_decode.sv
// single-pass decode of one registered input item into a result group and next state
module fuds_decode #(
    parameter int PAIR_INDEX_RANGE = fuds_pkg::PAIR_INDEX_RANGE_DEF
) (
    input  logic [7:0]                          in_byte,
    input  logic                                end_of_string,
    input  fuds_pkg::esc_phase_t                phase,
    input  logic [7:0]                          held,
    input  logic                                value_side,
    input  logic [$clog2(PAIR_INDEX_RANGE)-1:0] pair_count,
    input  logic [fuds_pkg::PAIR_LIMIT_W-1:0]   pair_limit,
    output fuds_pkg::esc_phase_t                phase_next,
    output logic [7:0]                          held_next,
    output logic                                value_side_next,
    output logic [$clog2(PAIR_INDEX_RANGE)-1:0] pair_count_next,
    output fuds_pkg::group_t                    grp
);

    localparam int CNT_W = $clog2(PAIR_INDEX_RANGE);
    localparam int CMP_W = (CNT_W > fuds_pkg::PAIR_LIMIT_W) ? CNT_W : fuds_pkg::PAIR_LIMIT_W;

    logic [1:0]       pre_n;
    logic             tail_en;
    logic             tail_mark;
    logic [7:0]       tail_byte;
    logic             handle;
    logic             dropped;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] lim_ext;
    fuds_pkg::slot_t  tail_slot;

    assign cnt_ext = CMP_W'(pair_count);
    assign lim_ext = CMP_W'(pair_limit);
    assign dropped = (cnt_ext >= lim_ext);

    always_comb begin
        pre_n           = 2'd0;
        tail_en         = 1'b0;
        tail_mark       = 1'b0;
        tail_byte       = 8'd0;
        handle          = 1'b0;
        phase_next      = phase;
        held_next       = held;
        value_side_next = value_side;
        pair_count_next = pair_count;

        if (end_of_string) begin
            case (phase)
                fuds_pkg::PH_PCT:   pre_n = 2'd1;
                fuds_pkg::PH_DIGIT: pre_n = 2'd2;
                default:            pre_n = 2'd0;
            endcase
            tail_en         = 1'b1;
            tail_mark       = 1'b1;
            phase_next      = fuds_pkg::PH_NONE;
            held_next       = 8'd0;
            value_side_next = 1'b0;
            pair_count_next = '0;
        end else begin
            case (phase)
                fuds_pkg::PH_PCT: begin
                    if (fuds_pkg::is_hex(in_byte)) begin
                        held_next  = in_byte;
                        phase_next = fuds_pkg::PH_DIGIT;
                    end else begin
                        pre_n      = 2'd1;
                        phase_next = fuds_pkg::PH_NONE;
                        held_next  = 8'd0;
                        handle     = 1'b1;
                    end
                end
                fuds_pkg::PH_DIGIT: begin
                    if (fuds_pkg::is_hex(in_byte)) begin
                        tail_en    = 1'b1;
                        tail_byte  = {fuds_pkg::hex_val(held), fuds_pkg::hex_val(in_byte)};
                        phase_next = fuds_pkg::PH_NONE;
                        held_next  = 8'd0;
                    end else begin
                        pre_n      = 2'd2;
                        phase_next = fuds_pkg::PH_NONE;
                        held_next  = 8'd0;
                        handle     = 1'b1;
                    end
                end
                default: begin
                    phase_next = fuds_pkg::PH_NONE;
                    handle     = 1'b1;
                end
            endcase

            if (handle) begin
                if (in_byte == fuds_pkg::CH_AMP) begin
                    tail_en         = 1'b1;
                    tail_mark       = 1'b1;
                    value_side_next = 1'b0;
                    if (pair_count != CNT_W'(PAIR_INDEX_RANGE - 1)) begin
                        pair_count_next = pair_count + 1'b1;
                    end
                end else if ((in_byte == fuds_pkg::CH_EQ) && !value_side) begin
                    value_side_next = 1'b1;
                end else if (in_byte == fuds_pkg::CH_PCT) begin
                    phase_next = fuds_pkg::PH_PCT;
                    held_next  = 8'd0;
                end else if (in_byte == fuds_pkg::CH_PLUS) begin
                    tail_en   = 1'b1;
                    tail_byte = fuds_pkg::CH_SPACE;
                end else begin
                    tail_en   = 1'b1;
                    tail_byte = in_byte;
                end
            end
        end
    end

    // assemble flushed escape bytes first, then the tail result
    always_comb begin
        tail_slot.data_byte = tail_mark ? 8'd0 : tail_byte;
        tail_slot.has_byte  = !tail_mark;
        tail_slot.pair_done = tail_mark;

        grp.slots[0] = '{data_byte: fuds_pkg::CH_PCT, has_byte: 1'b1, pair_done: 1'b0};
        grp.slots[1] = '{data_byte: held, has_byte: 1'b1, pair_done: 1'b0};
        grp.slots[2] = '0;
        case (pre_n)
            2'd0:    grp.slots[0] = tail_slot;
            2'd1:    grp.slots[1] = tail_slot;
            2'd2:    grp.slots[2] = tail_slot;
            default: grp.slots[2] = tail_slot;
        endcase

        grp.cnt        = dropped ? 2'd0 : (pre_n + {1'b0, tail_en});
        grp.value_part = value_side;
        grp.pair_index = cnt_ext[fuds_pkg::PAIR_INDEX_W-1:0];
    end

endmodule

// File: hdl/fuds_out_buf.sv
// result register holding one group and handing it out one transaction at a time
module fuds_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             grp_load,
    input  fuds_pkg::group_t grp_in,
    output logic             grp_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    logic             vld_reg, vld_next;
    logic [1:0]       total_reg, total_next;
    logic [1:0]       rd_reg, rd_next;
    fuds_pkg::group_t grp_reg, grp_next;
    fuds_pkg::slot_t  cur;
    logic             is_last;
    logic             take;

    assign is_last  = (rd_reg == (total_reg - 2'd1));
    assign take     = vld_reg && m_tready;
    assign grp_free = !vld_reg || (take && is_last);

    always_comb begin
        case (rd_reg)
            2'd0:    cur = grp_reg.slots[0];
            2'd1:    cur = grp_reg.slots[1];
            2'd2:    cur = grp_reg.slots[2];
            default: cur = grp_reg.slots[0];
        endcase
    end

    always_comb begin
        vld_next   = vld_reg;
        total_next = total_reg;
        rd_next    = rd_reg;
        grp_next   = grp_reg;
        if (grp_load && grp_free) begin
            vld_next   = (grp_in.cnt != 2'd0);
            total_next = grp_in.cnt;
            rd_next    = 2'd0;
            grp_next   = grp_in;
        end else if (take) begin
            if (is_last) begin
                vld_next = 1'b0;
            end else begin
                rd_next = rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= 1'b0;
            total_reg <= 2'd0;
            rd_reg    <= 2'd0;
        end else begin
            vld_reg   <= vld_next;
            total_reg <= total_next;
            rd_reg    <= rd_next;
        end
        grp_reg <= grp_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {6'd0, grp_reg.pair_index, cur.data_byte};
    assign m_tuser  = {cur.pair_done, cur.has_byte & grp_reg.value_part, cur.has_byte};
    assign m_tlast  = is_last;

endmodule

// File: hdl/form_urlencoded_splitter_decoder.sv
// top level of the streaming form-encoded name/value splitter and decoder
//
// input stream: one raw byte of the encoded string per transaction in s_tdata,
// with s_tlast high on a separate terminator transaction that closes the string
// result stream: one decoded byte tagged name or value, or an end-of-pair marker,
// per transaction; m_tlast marks the final result caused by one input transaction
// config: cfg_data sets the pair limit; pairs whose index reaches it give no results
// path: an accepted input waits in the input register until the result register
// is free, then its group is loaded there and m_tvalid rises if it has results
// throughput: one input transaction per cycle while each gives at most one result
// and m_tready stays high; an item with more than one result holds the single
// result register until all are taken, as it drains one transaction per cycle
// while m_tready is high; a new input is taken while the result register still
// waits on m_tready, so one input transaction sits in the input register in a stall
// reset: escape, part and pair state clear, pair limit returns to 509, both
// channels come up empty
// receiver stall: results hold steady, then the input register fills and
// s_tready falls until the result register empties
module form_urlencoded_splitter_decoder #(
    parameter int PAIR_INDEX_RANGE = fuds_pkg::PAIR_INDEX_RANGE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [17:8] pair_index, [23:18] zero
    output logic [2:0]  m_tuser,   // [0] has_byte, [1] in_value_part, [2] pair_done
    output logic        m_tlast,   // last
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data   // pair_limit
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(PAIR_INDEX_RANGE);

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_eos_reg, in_eos_next;

    // parser state
    fuds_pkg::esc_phase_t phase_reg, phase_next;
    logic [7:0]           held_reg, held_next;
    logic                 vs_reg, vs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [fuds_pkg::PAIR_LIMIT_W-1:0] limit_reg, limit_next;

    fuds_pkg::group_t grp;
    logic             grp_free;
    logic             adv;
    logic             s_take;

    // decoded item moves on whenever the result register can take its group
    assign adv      = in_vld_reg && grp_free;
    assign s_tready = !in_vld_reg || grp_free;
    assign s_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        in_eos_next  = in_eos_reg;
        if (s_take) begin
            in_vld_next  = 1'b1;
            in_byte_next = s_tdata;
            in_eos_next  = s_tlast;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
        limit_next = cfg_valid ? cfg_data : limit_reg;
    end

    fuds_decode #(
        .PAIR_INDEX_RANGE(PAIR_INDEX_RANGE)
    ) u_decode (
        .in_byte         (in_byte_reg),
        .end_of_string   (in_eos_reg),
        .phase           (phase_reg),
        .held            (held_reg),
        .value_side      (vs_reg),
        .pair_count      (cnt_reg),
        .pair_limit      (limit_reg),
        .phase_next      (phase_next),
        .held_next       (held_next),
        .value_side_next (vs_next),
        .pair_count_next (cnt_next),
        .grp             (grp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            phase_reg  <= fuds_pkg::PH_NONE;
            held_reg   <= 8'd0;
            vs_reg     <= 1'b0;
            cnt_reg    <= '0;
            limit_reg  <= fuds_pkg::PAIR_LIMIT_RST;
        end else begin
            in_vld_reg <= in_vld_next;
            limit_reg  <= limit_next;
            if (adv) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                vs_reg    <= vs_next;
                cnt_reg   <= cnt_next;
            end
        end
        in_byte_reg <= in_byte_next;
        in_eos_reg  <= in_eos_next;
    end

    fuds_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp_load (adv),
        .grp_in   (grp),
        .grp_free (grp_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // an end-of-pair marker carries no byte and closes its group
    `ASSERT_PROP(a_marker_empty, aclk, aresetn, (m_tvalid && m_tuser[2]) |-> (!m_tuser[0] && !m_tuser[1] && (m_tdata[7:0] == 8'd0)), "marker carries byte data")
    `ASSERT_PROP(a_marker_last, aclk, aresetn, (m_tvalid && m_tuser[2]) |-> m_tlast, "marker not last of its group")
    // the held digit is only live while waiting for the second digit
    `ASSERT_PROP(a_held_clear, aclk, aresetn, (phase_reg != fuds_pkg::PH_DIGIT) |-> (held_reg == 8'd0), "held digit outside digit phase")

endmodule
